// ----- hdl/tfce_pkg.sv -----
// ----------------------------------------------------------------------------
// tfce_pkg
// Shared types, codes and color expansion functions of the texel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tfce_pkg;

  // Pixel format codes. Codes 6 and 7 are unused and behave as raw 32-bit.
  localparam logic [2:0] PF_RAW32  = 3'd0;
  localparam logic [2:0] PF_RGB24  = 3'd1;
  localparam logic [2:0] PF_RGBA16 = 3'd2;
  localparam logic [2:0] PF_IDX8   = 3'd3;
  localparam logic [2:0] PF_IDX4   = 3'd4;
  localparam logic [2:0] PF_IDX8H  = 3'd5;

  // Item kinds carried on the input tuser.
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // Palette entry format and storage mode.
  localparam logic CEF_32BIT    = 1'b0;
  localparam logic CLUT_SWIZZLE = 1'b0;

  // Configuration register indexes.
  localparam logic [2:0] REG_PIXEL_FORMAT      = 3'd0;
  localparam logic [2:0] REG_CLUT_ENTRY_FORMAT = 3'd1;
  localparam logic [2:0] REG_CLUT_MODE         = 3'd2;
  localparam logic [2:0] REG_ALPHA_EXPAND_MODE = 3'd3;
  localparam logic [2:0] REG_ALPHA0            = 3'd4;
  localparam logic [2:0] REG_ALPHA1            = 3'd5;

  localparam logic [7:0] ALPHA1_RESET = 8'h80;

  typedef struct packed {
    logic [2:0] pixel_format;
    logic       clut_entry_format;
    logic       clut_mode;
    logic       alpha_expand_mode;
    logic [7:0] alpha0;
    logic [7:0] alpha1;
  } cfg_t;

  // One decoded convert item: up to two beats, each either a direct color
  // or a palette read (port A for the first beat, port B for the second).
  typedef struct packed {
    logic [31:0] color0;
    logic [31:0] color1;
    logic        pal0;
    logic        pal1;
    logic        oor0;
    logic        oor1;
    logic        two;
  } req_t;

  function automatic logic [23:0] expand_rgb15(input logic [15:0] c);
    return {c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
  endfunction

  // Alpha bit becomes 0x80 or 0x00.
  function automatic logic [31:0] expand16_bit(input logic [15:0] c);
    return {c[15], 7'b0, expand_rgb15(c)};
  endfunction

  // Alpha from alpha1/alpha0, with black-is-transparent when enabled.
  function automatic logic [31:0] expand16_texa(input logic [15:0] c, input cfg_t cfg);
    logic [7:0] a;
    if (c[15]) begin
      a = cfg.alpha1;
    end else if (cfg.alpha_expand_mode && (c[14:0] == 15'd0)) begin
      a = 8'd0;
    end else begin
      a = cfg.alpha0;
    end
    return {a, expand_rgb15(c)};
  endfunction

  function automatic logic [31:0] expand24(input logic [23:0] rgb, input cfg_t cfg);
    logic [7:0] a;
    a = (cfg.alpha_expand_mode && (rgb == 24'd0)) ? 8'd0 : cfg.alpha0;
    return {a, rgb};
  endfunction

  // Swaps index bits 3 and 4.
  function automatic logic [7:0] swizzle(input logic [7:0] idx);
    return {idx[7:5], idx[3], idx[4], idx[2:0]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tfce_ram.sv -----
// ----------------------------------------------------------------------------
// tfce_ram
// Generic RAM with one write port and two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tfce_cfg.sv -----
// ----------------------------------------------------------------------------
// tfce_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  output tfce_pkg::cfg_t     cfg
);
  import tfce_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format      <= PF_RAW32;
      cfg.clut_entry_format <= CEF_32BIT;
      cfg.clut_mode         <= CLUT_SWIZZLE;
      cfg.alpha_expand_mode <= 1'b0;
      cfg.alpha0            <= 8'd0;
      cfg.alpha1            <= ALPHA1_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT:      cfg.pixel_format      <= cfg_data[2:0];
        REG_CLUT_ENTRY_FORMAT: cfg.clut_entry_format <= cfg_data[0];
        REG_CLUT_MODE:         cfg.clut_mode         <= cfg_data[0];
        REG_ALPHA_EXPAND_MODE: cfg.alpha_expand_mode <= cfg_data[0];
        REG_ALPHA0:            cfg.alpha0            <= cfg_data;
        REG_ALPHA1:            cfg.alpha1            <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tfce_decode.sv -----
// ----------------------------------------------------------------------------
// tfce_decode
// Input register, palette store path and decode of convert items.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_decode #(
  parameter int unsigned PALETTE_DEPTH = 256,
  localparam int unsigned AW = $clog2(PALETTE_DEPTH)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic           s_tuser,
  input  wire logic [39:0]    s_tdata,
  input  wire tfce_pkg::cfg_t cfg,
  input  wire logic           down_ready,
  output logic                req_valid,
  output tfce_pkg::req_t      req,
  output logic [AW-1:0]       rd_addr_a,
  output logic [AW-1:0]       rd_addr_b,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [31:0]         wr_data
);
  import tfce_pkg::*;

  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  logic        in_valid;
  logic        in_cmd;
  logic [7:0]  in_idx;
  logic [31:0] in_data;
  logic        advance;
  logic [7:0]  idx_a;
  logic [7:0]  idx_b;
  logic [7:0]  pos;

  // A store finishes in this stage without waiting; a convert waits for the next stage.
  assign advance  = in_valid && ((in_cmd == CMD_STORE) || down_ready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_idx  <= s_tdata[7:0];
      in_data <= s_tdata[39:8];
    end
  end

  // Store path.
  always_comb begin
    pos     = in_idx;
    wr_data = in_data;
    if (cfg.clut_mode == CLUT_SWIZZLE) begin
      if (!(cfg.pixel_format == PF_IDX4 && cfg.clut_entry_format == CEF_32BIT)) begin
        pos = swizzle(in_idx);
      end
      if (cfg.clut_entry_format != CEF_32BIT) begin
        wr_data = expand16_bit(in_data[15:0]);
      end
    end else if (cfg.pixel_format == PF_IDX8) begin
      wr_data = expand16_texa(in_data[15:0], cfg);
    end else begin
      wr_data = expand16_bit(in_data[15:0]);
    end
  end

  assign wr_en   = in_valid && (in_cmd == CMD_STORE) && ({1'b0, pos} < DEPTH9);
  assign wr_addr = pos[AW-1:0];

  // Convert path.
  always_comb begin
    req.color0 = in_data;
    req.color1 = in_data;
    req.pal0   = 1'b0;
    req.pal1   = 1'b0;
    req.two    = 1'b0;
    idx_a      = in_data[7:0];
    idx_b      = in_data[7:0];
    unique case (cfg.pixel_format)
      PF_RGB24: begin
        req.color0 = expand24(in_data[23:0], cfg);
      end
      PF_RGBA16: begin
        req.color0 = expand16_texa(in_data[15:0], cfg);
        req.color1 = expand16_texa(in_data[31:16], cfg);
        req.two    = 1'b1;
      end
      PF_IDX8: begin
        req.pal0 = 1'b1;
      end
      PF_IDX4: begin
        idx_a    = {4'd0, in_data[3:0]};
        idx_b    = {4'd0, in_data[7:4]};
        req.pal0 = 1'b1;
        req.pal1 = 1'b1;
        req.two  = 1'b1;
      end
      PF_IDX8H: begin
        idx_a    = in_data[31:24];
        req.pal0 = 1'b1;
      end
      default: ;
    endcase
    req.oor0 = ({1'b0, idx_a} >= DEPTH9);
    req.oor1 = ({1'b0, idx_b} >= DEPTH9);
  end

  assign rd_addr_a = idx_a[AW-1:0];
  assign rd_addr_b = idx_b[AW-1:0];
  assign req_valid = advance && (in_cmd == CMD_CONVERT);

endmodule

`default_nettype wire

// ----- hdl/tfce_out.sv -----
// ----------------------------------------------------------------------------
// tfce_out
// Beat sequencing of one or two texels and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfce_out (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire tfce_pkg::req_t req_in,
  output logic                down_ready,
  input  wire logic [31:0]    rdata_a,
  input  wire logic [31:0]    rdata_b,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tlast
);
  import tfce_pkg::*;

  logic        busy;
  logic        second;
  req_t        req;
  logic        out_free;
  logic        push;
  logic        beat_last;
  logic [31:0] beat_color;

  assign out_free   = !m_tvalid || m_tready;
  assign push       = busy && out_free;
  assign beat_last  = !req.two || second;
  assign down_ready = !busy || (push && beat_last);

  // Palette read data stays put while this stage holds its item, since the
  // RAM is only read when a new item moves in.
  always_comb begin
    if (second) begin
      if (req.pal1) begin
        beat_color = req.oor1 ? 32'd0 : rdata_b;
      end else begin
        beat_color = req.color1;
      end
    end else if (req.pal0) begin
      beat_color = req.oor0 ? 32'd0 : rdata_a;
    end else begin
      beat_color = req.color0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (down_ready) begin
      busy   <= req_valid;
      second <= 1'b0;
    end else if (push) begin
      second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (down_ready && req_valid) begin
      req <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tdata <= beat_color;
      m_tlast <= beat_last;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/texel_format_clut_expander.sv -----
// ----------------------------------------------------------------------------
// texel_format_clut_expander
// Converts texel words to RGBA32 through a palette table or direct expansion.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tuser: command; tdata: clut_index, data
//  m_*     | out       | tdata: color; tlast: last
//  cfg_*   | in        | register index and 8-bit write data
//
// A beat passes the input register, the decode/palette read stage and the
// output register before its first result beat is on m_*.
// A texel word giving two texels yields two output beats, and the next
// convert item waits until the second beat moves into the output register;
// all others give one, and palette stores give none. The output port sets the rate.
// Reset clears the pipeline valids and the registers; the palette is not
// cleared. A stall on m_tready backs up through each stage in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module texel_format_clut_expander #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [7:0] clut_index, [39:8] data
  input  wire logic        s_tuser,   // [0] command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] color
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import tfce_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  cfg_t          cfg;
  req_t          req;
  logic          req_valid;
  logic          down_ready;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [31:0]   rdata_a;
  logic [31:0]   rdata_b;

  tfce_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfce_decode #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .down_ready (down_ready),
    .req_valid  (req_valid),
    .req        (req),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  tfce_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (req_valid),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  tfce_out u_out (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_in     (req),
    .down_ready (down_ready),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tfce_checker.sv -----
// ----------------------------------------------------------------------------
// tfce_checker
// Watches the stream, palette-store and register-write beats of the texel
// expander, keeps its own palette and register copy, predicts every RGBA32
// output beat and compares the block's output against it in order.
// ----------------------------------------------------------------------------
module tfce_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] clut_index, [39:8] data
  input  logic        s_tuser,   // [0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] color
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          outstanding
);
  import tfce_pkg::*;

  typedef struct packed {
    logic [31:0] color;
    logic        last;
  } texel_t;

  texel_t      texel_queue[$];
  logic [31:0] clut_table [0:255];

  logic [2:0]  pix_fmt;
  logic        entry16;
  logic        linear;
  logic        black_clear;
  logic [7:0]  alpha_lo;
  logic [7:0]  alpha_hi;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // A 1-5-5-5 texel to RGBA32. With bit_alpha set, bit 15 becomes 0x80;
  // otherwise the alpha registers apply, with black-is-transparent when enabled.
  function automatic logic [31:0] rgb555_to_rgba(input logic [15:0] c,
                                                 input logic bit_alpha);
    logic [7:0] a;
    if (bit_alpha) begin
      a = c[15] ? 8'h80 : 8'h00;
    end else if (c[15]) begin
      a = alpha_hi;
    end else if (black_clear && (c[14:0] == 15'd0)) begin
      a = 8'h00;
    end else begin
      a = alpha_lo;
    end
    return {a, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
  endfunction

  task automatic add_texel(input logic [31:0] color, input logic last);
    texel_t t;
    t.color = color;
    t.last  = last;
    texel_queue.push_back(t);
  endtask

  task automatic predict(input logic cmd, input logic [7:0] idx, input logic [31:0] word);
    logic [7:0]  pos;
    logic [31:0] entry;
    logic [23:0] rgb;
    pos = idx;
    if (cmd == CMD_STORE) begin
      if (!linear) begin
        // The 16-entry table of 4-bit texels with 32-bit entries is not swizzled.
        if (!(pix_fmt == PF_IDX4 && !entry16)) begin
          pos = {idx[7:5], idx[3], idx[4], idx[2:0]};
        end
        entry = entry16 ? rgb555_to_rgba(word[15:0], 1'b1) : word;
      end else begin
        entry = rgb555_to_rgba(word[15:0], pix_fmt != PF_IDX8);
      end
      clut_table[pos] = entry;
    end else begin
      case (pix_fmt)
        PF_RGB24: begin
          rgb = word[23:0];
          add_texel({(black_clear && rgb == 24'd0) ? 8'h00 : alpha_lo, rgb}, 1'b1);
        end
        PF_RGBA16: begin
          add_texel(rgb555_to_rgba(word[15:0], 1'b0), 1'b0);
          add_texel(rgb555_to_rgba(word[31:16], 1'b0), 1'b1);
        end
        PF_IDX8: begin
          add_texel(clut_table[word[7:0]], 1'b1);
        end
        PF_IDX4: begin
          add_texel(clut_table[{4'd0, word[3:0]}], 1'b0);
          add_texel(clut_table[{4'd0, word[7:4]}], 1'b1);
        end
        PF_IDX8H: begin
          add_texel(clut_table[word[31:24]], 1'b1);
        end
        default: begin
          add_texel(word, 1'b1);
        end
      endcase
    end
  endtask

  task automatic check_texel(input logic [31:0] color, input logic last);
    texel_t want;
    if (texel_queue.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: unexpected texel color=%08h last=%0b", $realtime, color, last);
      end
    end else begin
      want = texel_queue.pop_front();
      if (color !== want.color || last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: texel mismatch: expected color=%08h last=%0b, got color=%08h last=%0b",
                   $realtime, want.color, want.last, color, last);
        end
      end
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      REG_PIXEL_FORMAT:      pix_fmt     = val[2:0];
      REG_CLUT_ENTRY_FORMAT: entry16     = (val[0] != CEF_32BIT);
      REG_CLUT_MODE:         linear      = (val[0] != CLUT_SWIZZLE);
      REG_ALPHA_EXPAND_MODE: black_clear = val[0];
      REG_ALPHA0:            alpha_lo    = val;
      REG_ALPHA1:            alpha_hi    = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pix_fmt     = PF_RAW32;
      entry16     = 1'b0;
      linear      = 1'b0;
      black_clear = 1'b0;
      alpha_lo    = 8'h00;
      alpha_hi    = ALPHA1_RESET;
      texel_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_texel(m_tdata, m_tlast);
      end
      if (s_tvalid && s_tready) begin
        predict(s_tuser, s_tdata[7:0], s_tdata[39:8]);
      end
      if (cfg_valid && cfg_ready) begin
        set_reg(cfg_index, cfg_data);
      end
    end
    outstanding = texel_queue.size();
  end

endmodule

// ----- tb/sv/tb_texel_format_clut_expander.sv -----
// ----------------------------------------------------------------------------
// tb_texel_format_clut_expander
// Fills the palette, runs directed texel and palette cases for every pixel
// format and storage mode, then random segments under changing registers
// and idle patterns. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_texel_format_clut_expander;
  import tfce_pkg::*;

  localparam logic       CEF_16BIT   = ~CEF_32BIT;
  localparam logic       CLUT_LINEAR = ~CLUT_SWIZZLE;
  localparam logic [2:0] PF_UNUSED6  = 3'd6;
  localparam logic [2:0] PF_UNUSED7  = 3'd7;
  localparam int         STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [7:0] clut_index, [39:8] data
  logic        s_tuser = CMD_STORE;   // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // [31:0] color
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_PIXEL_FORMAT;
  logic [7:0]  cfg_data = 8'h00;

  int errors;
  int outstanding;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  texel_format_clut_expander u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tfce_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Any accepted beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_texel_format_clut_expander: errors");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(input logic cmd, input logic [7:0] idx, input logic [31:0] word);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {word, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stores give no output, so the task waits on after the queue empties to let them leave the pipeline.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(input logic [2:0] pf, input logic cef, input logic cm,
                          input logic aem, input logic [7:0] a0, input logic [7:0] a1);
    wait_drained();
    write_reg(REG_PIXEL_FORMAT, {5'd0, pf});
    write_reg(REG_CLUT_ENTRY_FORMAT, {7'd0, cef});
    write_reg(REG_CLUT_MODE, {7'd0, cm});
    write_reg(REG_ALPHA_EXPAND_MODE, {7'd0, aem});
    write_reg(REG_ALPHA0, a0);
    write_reg(REG_ALPHA1, a1);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Biased toward black and alpha-only halves so the transparency rules fire.
  function automatic logic [31:0] texel_word();
    case ($urandom_range(0, 7))
      0:       return {$urandom_range(0, 1) ? 16'h8000 : 16'h0000,
                       $urandom_range(0, 1) ? 16'h8000 : 16'h0000};
      1:       return {8'($urandom), 24'h000000};
      2:       return 32'hffffffff;
      3:       return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Write every palette entry once so that no lookup reads an unwritten one.
    set_mode(PF_RAW32, CEF_32BIT, CLUT_LINEAR, 1'b0, 8'h00, 8'h80);
    for (int i = 0; i < 256; i++) begin
      push_item(CMD_STORE, 8'(i), $urandom);
    end

    set_mode(PF_RAW32, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h00);
    push_item(CMD_CONVERT, 8'h00, 32'h00000000);
    push_item(CMD_CONVERT, 8'hff, 32'hffffffff);
    set_mode(PF_UNUSED7, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h00);
    push_item(CMD_CONVERT, 8'h5a, $urandom);
    set_mode(PF_UNUSED6, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h00);
    push_item(CMD_CONVERT, 8'ha5, $urandom);

    set_mode(PF_RGB24, CEF_32BIT, CLUT_SWIZZLE, 1'b1, 8'hff, 8'h00);
    push_item(CMD_CONVERT, 8'h00, 32'hff000000);
    push_item(CMD_CONVERT, 8'h00, 32'h00000001);
    set_mode(PF_RGB24, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h3c, 8'h00);
    push_item(CMD_CONVERT, 8'h00, 32'h12000000);

    set_mode(PF_RGBA16, CEF_32BIT, CLUT_SWIZZLE, 1'b1, 8'h5a, 8'hff);
    push_item(CMD_CONVERT, 8'h00, 32'h80000000);
    push_item(CMD_CONVERT, 8'h00, 32'h7fff0001);
    push_item(CMD_CONVERT, 8'h00, 32'h00008000);
    push_item(CMD_CONVERT, 8'h00, 32'hffffffff);

    // Swizzled storage swaps index bits 3 and 4 on the way in.
    set_mode(PF_IDX8, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h80);
    push_item(CMD_STORE, 8'h08, 32'ha1b2c3d4);
    push_item(CMD_STORE, 8'h10, 32'h01020304);
    push_item(CMD_CONVERT, 8'h00, 32'h00000008);
    push_item(CMD_CONVERT, 8'h00, 32'habcdef10);
    set_mode(PF_IDX8, CEF_16BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h80);
    push_item(CMD_STORE, 8'hf7, 32'hffff8000);
    push_item(CMD_STORE, 8'h18, 32'h00007fff);
    push_item(CMD_CONVERT, 8'h00, 32'h000000ef);
    push_item(CMD_CONVERT, 8'h00, 32'h00000018);

    // The 16-entry table with 32-bit entries keeps indices as given.
    set_mode(PF_IDX4, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h80);
    push_item(CMD_STORE, 8'h08, $urandom);
    push_item(CMD_CONVERT, 8'h00, 32'h123456f8);

    // Linear storage with 8-bit indices uses the alpha register rule.
    set_mode(PF_IDX8, CEF_32BIT, CLUT_LINEAR, 1'b1, 8'h40, 8'hc0);
    push_item(CMD_STORE, 8'h20, 32'hffff0000);
    push_item(CMD_STORE, 8'h21, 32'h00008001);
    push_item(CMD_STORE, 8'h22, 32'h00001234);
    push_item(CMD_CONVERT, 8'h00, 32'h00000020);
    push_item(CMD_CONVERT, 8'h00, 32'h00000021);
    push_item(CMD_CONVERT, 8'h00, 32'h00000022);
    set_mode(PF_IDX8H, CEF_32BIT, CLUT_SWIZZLE, 1'b0, 8'h00, 8'h80);
    push_item(CMD_CONVERT, 8'h00, 32'h21000000);
    push_item(CMD_CONVERT, 8'h00, 32'hff0000ff);

    for (int seg = 0; seg < 12; seg++) begin
      set_mode((seg == 11) ? PF_UNUSED7 : 3'(seg % 6), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               pick_alpha(), pick_alpha());
      case (seg % 4)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 51; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 51; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      for (int n = 0; n < 75; n++) begin
        if ((seg % 2 == 1) && n == 37) begin
          wait_drained();
        end
        if ($urandom_range(0, 9) < 3) begin
          push_item(CMD_STORE, 8'($urandom), $urandom);
        end else begin
          push_item(CMD_CONVERT, 8'($urandom), texel_word());
        end
      end
    end

    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_texel_format_clut_expander: clean");
    end else begin
      $display("tb_texel_format_clut_expander: errors");
    end
    $finish;
  end

endmodule
